FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, off while reset is held
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("idw check failed");

// condition that must never hold
`define ASSERT_NEVER(lbl, clk, rst_n, cond) `ASSERT_CLK(lbl, clk, rst_n, !(cond))

`endif

FILE: hdl/idw_pkg.sv
`default_nettype none

package idw_pkg;

	localparam int MAX_POINTS_DEF = 256;
	localparam int COORD_BITS_DEF = 12;
	localparam int IN_COORD_W     = 12;
	localparam int VAL_W          = 16;
	localparam int OUT_W          = 32;
	localparam int STAT_W         = 3;
	localparam int HELD_W         = 9;
	localparam int CMD_W          = 2;
	localparam int T_W            = 21;
	localparam int W_W            = 2 * T_W;
	localparam int FRAC_D         = 8;
	localparam int FRAC_Q         = 16;
	localparam int QUEUE_DEPTH    = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_LOAD   = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 3'd0,
		ST_HIT   = 3'd1,
		ST_EMPTY = 3'd2,
		ST_ZERO  = 3'd3,
		ST_FULL  = 3'd4
	} status_t;

	typedef struct packed {
		cmd_t                  op;
		logic [IN_COORD_W-1:0] x;
		logic [IN_COORD_W-1:0] y;
		logic [VAL_W-1:0]      v;
	} job_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

`default_nettype wire

FILE: hdl/idw_ifs.sv
`default_nettype none

interface idw_in_if import idw_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        command;
	logic [IN_COORD_W-1:0]   coord_x;
	logic [IN_COORD_W-1:0]   coord_y;
	logic signed [VAL_W-1:0] sample_value;

	modport source(output valid, command, coord_x, coord_y, sample_value, input ready);
	modport sink(input valid, command, coord_x, coord_y, sample_value, output ready);
endinterface

interface idw_out_if import idw_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] interpolated;
	logic [STAT_W-1:0]       status;
	logic [HELD_W-1:0]       points_held;

	modport source(output valid, interpolated, status, points_held, input ready);
	modport sink(input valid, interpolated, status, points_held, output ready);
endinterface

`default_nettype wire

FILE: hdl/idw_div.sv
`default_nettype none

module idw_div import idw_pkg::*; #(
	parameter int NUM_W = W_W + FRAC_Q,
	parameter int DEN_W = W_W + 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo,
	output unit_stat_t       stat
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				num_q  <= num;
				den_q  <= den;
				rem_q  <= '0;
				cnt_q  <= CNT_W'(NUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				num_q <= {num_q[NUM_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quo       = num_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

FILE: hdl/idw_sqrt.sv
`default_nettype none

module idw_sqrt import idw_pkg::*; #(
	parameter int RT_W = COORD_BITS_DEF + 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [2*RT_W-1:0] op,
	output logic [RT_W-1:0]   root,
	output unit_stat_t        stat
);

	localparam int CNT_W = $clog2(RT_W + 1);

	logic [2*RT_W-1:0] op_q;
	logic [RT_W:0]     rem_q;
	logic [RT_W-1:0]   root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [RT_W+2:0]   shifted;
	logic [RT_W+2:0]   trial;
	logic [RT_W+2:0]   diff;
	logic              ge;

	// two operand bits, one root bit per cycle
	assign shifted = {rem_q, op_q[2*RT_W-1 -: 2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign diff    = shifted - trial;
	assign ge      = shifted >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				op_q   <= op;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= CNT_W'(RT_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= ge ? diff[RT_W:0] : shifted[RT_W:0];
				root_q <= {root_q[RT_W-2:0], ge};
				op_q   <= {op_q[2*RT_W-3:0], 2'b00};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign root      = root_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

FILE: hdl/idw_front.sv
`default_nettype none
`include "assert_macros.svh"

module idw_front import idw_pkg::*; #(
	parameter int QD = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	idw_in_if.sink req,
	output job_t  job,
	output logic  job_vld,
	input  logic  job_rdy
);

	localparam int PTR_W = (QD > 1) ? $clog2(QD) : 1;
	localparam int CNT_W = $clog2(QD + 1);

	job_t             q_mem [QD];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;
	cmd_t             op;

	assign req.ready = cnt_q != CNT_W'(QD);
	assign push      = req.valid && req.ready;
	assign pop       = job_vld && job_rdy;
	assign job_vld   = cnt_q != '0;
	assign job       = q_mem[rd_q];

	always_comb begin
		unique case (req.command)
			CMD_CLEAR: op = CMD_CLEAR;
			CMD_LOAD:  op = CMD_LOAD;
			CMD_QUERY: op = CMD_QUERY;
			default:   op = CMD_UNUSED;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_q] <= '{op: op, x: req.coord_x, y: req.coord_y, v: req.sample_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QD - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QD - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`ASSERT_CLK(a_q_bound, clk, arst_n, cnt_q <= CNT_W'(QD))
	`ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && cnt_q == '0)
	`ASSERT_CLK(a_push_grow, clk, arst_n, (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)

endmodule

`default_nettype wire

FILE: hdl/idw_back.sv
`default_nettype none
`include "assert_macros.svh"

module idw_back import idw_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  job_t        job,
	input  logic        job_vld,
	output logic        job_rdy,
	idw_out_if.source   rsp
);

	localparam int CB     = COORD_BITS;
	localparam int IDX_W  = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int EXT_W  = (CB > IN_COORD_W) ? CB : IN_COORD_W;
	localparam int D2_W   = 2 * CB + 1;
	localparam int DIST_W = CB + 9;
	localparam int SQ_W   = 2 * DIST_W;
	localparam int S_W    = W_W + CNT_W;
	localparam int DN_W   = W_W + FRAC_Q;
	localparam int Q_W    = FRAC_Q + 1;
	localparam int PROD_W = VAL_W + Q_W + 1;
	localparam logic [T_W-1:0] T_MAX = '1;

	typedef struct packed {
		logic [CB-1:0]    x;
		logic [CB-1:0]    y;
		logic [VAL_W-1:0] v;
	} pt_t;

	typedef enum logic [3:0] {
		S_IDLE, S_P1_RD, S_P1_D2, S_P1_SQ,
		S_P2_RD, S_P2_GO, S_P2_DIV, S_P2_SQ, S_P2_END,
		S_P3_RD, S_P3_GO, S_P3_DIV, S_P3_MUL, S_FIN
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [IDX_W-1:0]        idx_q;
	logic [CB-1:0]           qx_q;
	logic [CB-1:0]           qy_q;
	logic [DIST_W-1:0]       r_q;
	logic [S_W-1:0]          s_q;
	logic [T_W-1:0]          t_q;
	logic [Q_W-1:0]          q_q;
	logic signed [OUT_W-1:0] acc_q;
	logic signed [OUT_W-1:0] res_val_q;
	status_t                 res_st_q;
	logic                    out_vld_q;
	logic signed [OUT_W-1:0] out_val_q;
	status_t                 out_st_q;
	logic [HELD_W-1:0]       out_held_q;

	pt_t               pt_mem   [MAX_POINTS];
	logic [DIST_W-1:0] dist_mem [MAX_POINTS];
	logic [W_W-1:0]    wt_mem   [MAX_POINTS];
	pt_t               pt_rd_q;
	logic [DIST_W-1:0] dist_rd_q;
	logic [W_W-1:0]    wt_rd_q;

	logic [EXT_W-1:0]         jx_e;
	logic [EXT_W-1:0]         jy_e;
	logic [CB-1:0]            jx;
	logic [CB-1:0]            jy;
	logic                     pt_we;
	logic                     dist_we;
	logic                     wt_we;
	logic [CB-1:0]            dx;
	logic [CB-1:0]            dy;
	logic [D2_W-1:0]          d2;
	logic                     sq_start;
	logic [SQ_W-1:0]          sq_op;
	logic [DIST_W-1:0]        sq_root;
	unit_stat_t               sq_stat;
	logic                     div_start;
	logic [DN_W-1:0]          div_num;
	logic [S_W-1:0]           div_den;
	logic [DN_W-1:0]          div_quo;
	unit_stat_t               div_stat;
	logic [T_W-1:0]           t_sat;
	logic [W_W-1:0]           w;
	logic signed [PROD_W-1:0] prod;
	logic                     last;

	assign jx_e = EXT_W'(job.x);
	assign jy_e = EXT_W'(job.y);
	assign jx   = jx_e[CB-1:0];
	assign jy   = jy_e[CB-1:0];

	assign job_rdy = state_q == S_IDLE;
	assign pt_we   = (state_q == S_IDLE) && job_vld && (job.op == CMD_LOAD)
		&& (cnt_q != CNT_W'(MAX_POINTS));
	assign dist_we = (state_q == S_P1_SQ) && sq_stat.done;
	assign wt_we   = state_q == S_P2_SQ;
	assign last    = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_q;

	assign dx = (qx_q >= pt_rd_q.x) ? qx_q - pt_rd_q.x : pt_rd_q.x - qx_q;
	assign dy = (qy_q >= pt_rd_q.y) ? qy_q - pt_rd_q.y : pt_rd_q.y - qy_q;
	assign d2 = D2_W'(dx) * D2_W'(dx) + D2_W'(dy) * D2_W'(dy);

	assign sq_start = (state_q == S_P1_D2) && (d2 != '0);
	assign sq_op    = SQ_W'({d2, {FRAC_Q{1'b0}}});

	assign div_start = (state_q == S_P2_GO) || (state_q == S_P3_GO);
	assign div_num   = (state_q == S_P3_GO) ? {wt_rd_q, {FRAC_Q{1'b0}}}
		: DN_W'({r_q - dist_rd_q, {FRAC_D{1'b0}}});
	assign div_den   = (state_q == S_P3_GO) ? s_q : S_W'(dist_rd_q);

	assign t_sat = (div_quo > DN_W'(T_MAX)) ? T_MAX : div_quo[T_W-1:0];
	assign w     = W_W'(t_q) * W_W'(t_q);
	assign prod  = PROD_W'($signed(pt_rd_q.v)) * PROD_W'($signed({1'b0, q_q}));

	idw_sqrt #(.RT_W(DIST_W)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.op     (sq_op),
		.root   (sq_root),
		.stat   (sq_stat)
	);

	idw_div #(.NUM_W(DN_W), .DEN_W(S_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.stat   (div_stat)
	);

	always_ff @(posedge clk) begin
		if (pt_we) begin
			pt_mem[cnt_q[IDX_W-1:0]] <= '{x: jx, y: jy, v: job.v};
		end
		pt_rd_q <= pt_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[idx_q] <= sq_root;
		end
		dist_rd_q <= dist_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (wt_we) begin
			wt_mem[idx_q] <= w;
		end
		wt_rd_q <= wt_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			idx_q      <= '0;
			qx_q       <= '0;
			qy_q       <= '0;
			r_q        <= '0;
			s_q        <= '0;
			t_q        <= '0;
			q_q        <= '0;
			acc_q      <= '0;
			res_val_q  <= '0;
			res_st_q   <= ST_OK;
			out_vld_q  <= 1'b0;
			out_val_q  <= '0;
			out_st_q   <= ST_OK;
			out_held_q <= '0;
		end else begin
			if (rsp.ready && state_q != S_FIN) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (job_vld) begin
						res_val_q <= '0;
						res_st_q  <= ST_OK;
						state_q   <= S_FIN;
						unique case (job.op)
							CMD_CLEAR: cnt_q <= '0;
							CMD_LOAD: begin
								if (cnt_q == CNT_W'(MAX_POINTS)) begin
									res_st_q <= ST_FULL;
								end else begin
									cnt_q <= cnt_q + 1'b1;
								end
							end
							CMD_QUERY: begin
								if (cnt_q == '0) begin
									res_st_q <= ST_EMPTY;
								end else begin
									qx_q    <= jx;
									qy_q    <= jy;
									idx_q   <= '0;
									r_q     <= '0;
									s_q     <= '0;
									acc_q   <= '0;
									state_q <= S_P1_RD;
								end
							end
							default: ;
						endcase
					end
				end
				S_P1_RD: state_q <= S_P1_D2;
				S_P1_D2: begin
					if (d2 == '0) begin
						res_val_q <= $signed({pt_rd_q.v, {FRAC_Q{1'b0}}});
						res_st_q  <= ST_HIT;
						state_q   <= S_FIN;
					end else begin
						state_q <= S_P1_SQ;
					end
				end
				S_P1_SQ: begin
					if (sq_stat.done) begin
						if (sq_root > r_q) begin
							r_q <= sq_root;
						end
						if (last) begin
							idx_q   <= '0;
							state_q <= S_P2_RD;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_P1_RD;
						end
					end
				end
				S_P2_RD: state_q <= S_P2_GO;
				S_P2_GO: state_q <= S_P2_DIV;
				S_P2_DIV: begin
					if (div_stat.done) begin
						t_q     <= t_sat;
						state_q <= S_P2_SQ;
					end
				end
				S_P2_SQ: begin
					s_q <= s_q + S_W'(w);
					if (last) begin
						state_q <= S_P2_END;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_P2_RD;
					end
				end
				S_P2_END: begin
					if (s_q == '0) begin
						res_st_q <= ST_ZERO;
						state_q  <= S_FIN;
					end else begin
						idx_q   <= '0;
						state_q <= S_P3_RD;
					end
				end
				S_P3_RD: state_q <= S_P3_GO;
				S_P3_GO: state_q <= S_P3_DIV;
				S_P3_DIV: begin
					if (div_stat.done) begin
						q_q     <= div_quo[Q_W-1:0];
						state_q <= S_P3_MUL;
					end
				end
				S_P3_MUL: begin
					acc_q <= acc_q + OUT_W'(prod);
					if (last) begin
						res_val_q <= acc_q + OUT_W'(prod);
						state_q   <= S_FIN;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_P3_RD;
					end
				end
				S_FIN: begin
					if (!out_vld_q || rsp.ready) begin
						out_vld_q  <= 1'b1;
						out_val_q  <= res_val_q;
						out_st_q   <= res_st_q;
						out_held_q <= HELD_W'(cnt_q);
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.interpolated = out_val_q;
	assign rsp.status       = out_st_q;
	assign rsp.points_held  = out_held_q;

	`ASSERT_CLK(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(MAX_POINTS))
	`ASSERT_CLK(a_div_owner, clk, arst_n, div_stat.busy |-> (state_q == S_P2_DIV || state_q == S_P3_DIV))
	`ASSERT_CLK(a_sqrt_owner, clk, arst_n, sq_stat.busy |-> state_q == S_P1_SQ)

endmodule

`default_nettype wire

FILE: hdl/shepard_idw_interpolator_core.sv
`default_nettype none

// channel  dir  words
// req      in   command, coord_x, coord_y, sample_value
// rsp      out  interpolated, status, points_held
//
// Clear, load and unused commands pass from idle straight to the finish state.
// A query over n points runs, per point, the square root (COORD_BITS+9 steps)
// and two passes through the shared bit-serial divider (58 steps each).
// arst_n clears the point count and all control; the point tables hold no reset.
// A two-word queue takes new words while the back end works or a result waits.

module shepard_idw_interpolator_core import idw_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	idw_in_if.sink    req,
	idw_out_if.source rsp
);

	job_t job;
	logic job_vld;
	logic job_rdy;

	idw_front #(.QD(QUEUE_DEPTH)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.job     (job),
		.job_vld (job_vld),
		.job_rdy (job_rdy)
	);

	idw_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.job     (job),
		.job_vld (job_vld),
		.job_rdy (job_rdy),
		.rsp     (rsp)
	);

endmodule

`default_nettype wire

FILE: bench/tb_shepard_idw_interpolator_core.sv
`timescale 1ns / 100ps

module tb_shepard_idw_interpolator_core;
	import idw_pkg::*;

	localparam int N_PTS = 256;
	localparam int ITEMS = 580;
	localparam int STALL_LIMIT = 200000;

	typedef struct {
		logic [31:0] interp;
		status_t     status;
		logic [8:0]  held;
	} idw_result_t;

	typedef struct {
		cmd_t        op;
		logic [11:0] x;
		logic [11:0] y;
		logic [15:0] v;
		bit          fixed;
		idw_result_t res;
	} dir_row_t;

	localparam idw_result_t NO_RES = '{32'h0, ST_OK, 9'd0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	idw_in_if  req();
	idw_out_if rsp();

	shepard_idw_interpolator_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	logic [11:0] pt_x [N_PTS];
	logic [11:0] pt_y [N_PTS];
	logic [15:0] pt_v [N_PTS];
	int unsigned pt_count = 0;

	idw_result_t pending_results[$];
	dir_row_t    dir_rows[$];
	int unsigned src_idle = 17;
	int unsigned snk_idle = 58;
	int unsigned words_sent = 0;
	int unsigned stall_cycles = 0;
	bit          failed = 0;

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned idw_weight(longint unsigned r, longint unsigned d);
		longint unsigned t;
		if (d == 0 || d > r)
			return 0;
		t = ((r - d) << 8) / d;
		if (t > 64'h1FFFFF)
			t = 64'h1FFFFF;
		return t * t;
	endfunction

	function automatic idw_result_t idw_predict(cmd_t op, logic [11:0] x, logic [11:0] y,
			logic [15:0] v);
		idw_result_t     res;
		longint unsigned dists [N_PTS];
		longint unsigned r, s, dx, dy, d2, q;
		longint          acc;
		res.interp = '0;
		res.status = ST_OK;
		r = 0;
		s = 0;
		acc = 0;
		case (op)
			CMD_CLEAR: pt_count = 0;
			CMD_LOAD: begin
				if (pt_count >= N_PTS) begin
					res.status = ST_FULL;
				end else begin
					pt_x[pt_count] = x;
					pt_y[pt_count] = y;
					pt_v[pt_count] = v;
					pt_count++;
				end
			end
			CMD_QUERY: begin
				if (pt_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					for (int i = 0; i < pt_count; i++) begin
						dx = x > pt_x[i] ? x - pt_x[i] : pt_x[i] - x;
						dy = y > pt_y[i] ? y - pt_y[i] : pt_y[i] - y;
						d2 = dx * dx + dy * dy;
						if (d2 == 0) begin
							res.interp = 32'(longint'($signed(pt_v[i])) * 65536);
							res.status = ST_HIT;
							res.held = pt_count[8:0];
							return res;
						end
						dists[i] = int_sqrt(d2 << 16);
						if (dists[i] > r)
							r = dists[i];
					end
					for (int i = 0; i < pt_count; i++)
						s += idw_weight(r, dists[i]);
					if (s == 0) begin
						res.status = ST_ZERO;
					end else begin
						for (int i = 0; i < pt_count; i++) begin
							q = (idw_weight(r, dists[i]) << 16) / s;
							acc += longint'($signed(pt_v[i])) * longint'(q);
						end
						res.interp = acc[31:0];
					end
				end
			end
			default: ;
		endcase
		res.held = pt_count[8:0];
		return res;
	endfunction

	task automatic send_word(cmd_t op, logic [11:0] x, logic [11:0] y, logic [15:0] v,
			bit fixed = 0, idw_result_t typed = NO_RES);
		idw_result_t res;
		res = idw_predict(op, x, y, v);
		pending_results.insert(pending_results.size(), fixed ? typed : res);
		if (words_sent < ITEMS / 3) begin
			src_idle = 17;
			snk_idle = 58;
		end else if (words_sent < 2 * ITEMS / 3) begin
			src_idle = 58;
			snk_idle = 17;
		end else begin
			src_idle = 0;
			snk_idle = 0;
		end
		while ($urandom_range(99) < src_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.command <= op;
		req.coord_x <= x;
		req.coord_y <= y;
		req.sample_value <= v;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		words_sent++;
	endtask

	function automatic logic [11:0] rand_coord();
		return $urandom_range(1) ? 12'($urandom_range(4095)) : 12'($urandom_range(31));
	endfunction

	task automatic rand_query();
		logic [11:0] x, y;
		int unsigned k, pick;
		k = $urandom_range(9);
		x = rand_coord();
		y = rand_coord();
		if (pt_count != 0 && k < 5) begin
			pick = $urandom_range(pt_count - 1);
			x = pt_x[pick];
			y = pt_y[pick];
			if (k >= 3) begin
				x = x ^ 12'($urandom_range(3));
				y = y ^ 12'($urandom_range(3));
			end
		end
		send_word(CMD_QUERY, x, y, 16'($urandom));
	endtask

	always @(posedge clk or negedge arst_n) begin
		idw_result_t e;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_cycles <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected word: interpolated %h status %0d held %0d",
						rsp.interpolated, rsp.status, rsp.points_held);
					failed = 1;
				end else begin
					e = pending_results.pop_front();
					if (rsp.interpolated !== e.interp) begin
						$error("interpolated: expected %h, got %h", e.interp, rsp.interpolated);
						failed = 1;
					end
					if (rsp.status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, rsp.status);
						failed = 1;
					end
					if (rsp.points_held !== e.held) begin
						$error("points_held: expected %0d, got %0d", e.held, rsp.points_held);
						failed = 1;
					end
				end
			end
			rsp.ready <= ($urandom_range(99) >= snk_idle);
			if ((rsp.valid && rsp.ready) || (req.valid && req.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned k;
		req.valid = 1'b0;
		req.command = CMD_CLEAR;
		req.coord_x = '0;
		req.coord_y = '0;
		req.sample_value = '0;

		dir_rows.insert(dir_rows.size(),
			'{CMD_QUERY,  12'd0,    12'd0,    16'h1234, 1, '{32'h0, ST_EMPTY, 9'd0}});
		dir_rows.insert(dir_rows.size(),
			'{CMD_UNUSED, 12'hFFF,  12'hFFF,  16'hFFFF, 1, '{32'h0, ST_OK, 9'd0}});
		dir_rows.insert(dir_rows.size(),
			'{CMD_LOAD,   12'd0,    12'd0,    16'h8000, 1, '{32'h0, ST_OK, 9'd1}});
		dir_rows.insert(dir_rows.size(),
			'{CMD_QUERY,  12'd0,    12'd0,    16'h0,    1, '{32'h80000000, ST_HIT, 9'd1}});
		dir_rows.insert(dir_rows.size(),
			'{CMD_QUERY,  12'hFFF,  12'hFFF,  16'h0,    1, '{32'h0, ST_ZERO, 9'd1}});
		dir_rows.insert(dir_rows.size(),
			'{CMD_LOAD,   12'hFFF,  12'hFFF,  16'h7FFF, 1, '{32'h0, ST_OK, 9'd2}});
		dir_rows.insert(dir_rows.size(),
			'{CMD_QUERY,  12'hFFF,  12'hFFF,  16'h0,    1, '{32'h7FFF0000, ST_HIT, 9'd2}});
		dir_rows.insert(dir_rows.size(),
			'{CMD_QUERY,  12'h800,  12'h800,  16'h0,    0, NO_RES});
		dir_rows.insert(dir_rows.size(),
			'{CMD_QUERY,  12'd0,    12'hFFF,  16'h0,    1, '{32'h0, ST_ZERO, 9'd2}});
		dir_rows.insert(dir_rows.size(),
			'{CMD_LOAD,   12'd0,    12'hFFF,  16'h0001, 0, NO_RES});
		dir_rows.insert(dir_rows.size(),
			'{CMD_QUERY,  12'd1,    12'd2,    16'h0,    0, NO_RES});
		dir_rows.insert(dir_rows.size(),
			'{CMD_QUERY,  12'hFFE,  12'h7FF,  16'hFFFF, 0, NO_RES});
		dir_rows.insert(dir_rows.size(),
			'{CMD_LOAD,   12'hAAA,  12'h555,  16'h5555, 0, NO_RES});
		dir_rows.insert(dir_rows.size(),
			'{CMD_LOAD,   12'h555,  12'hAAA,  16'hAAAA, 0, NO_RES});
		dir_rows.insert(dir_rows.size(),
			'{CMD_QUERY,  12'h800,  12'h7FF,  16'h0,    0, NO_RES});
		dir_rows.insert(dir_rows.size(),
			'{CMD_UNUSED, 12'h123,  12'h456,  16'h789A, 1, '{32'h0, ST_OK, 9'd5}});
		dir_rows.insert(dir_rows.size(),
			'{CMD_CLEAR,  12'hFFF,  12'hFFF,  16'hFFFF, 1, '{32'h0, ST_OK, 9'd0}});
		dir_rows.insert(dir_rows.size(),
			'{CMD_QUERY,  12'd5,    12'd5,    16'h0,    1, '{32'h0, ST_EMPTY, 9'd0}});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].v,
				dir_rows[i].fixed, dir_rows[i].res);

		while (words_sent < ITEMS) begin
			if (words_sent > 150 && words_sent < 200) begin
				req.valid <= 1'b0;
				while (pending_results.size() != 0)
					@(posedge clk);
				send_word(CMD_CLEAR, rand_coord(), rand_coord(), 16'($urandom));
				for (int i = 0; i < N_PTS; i++)
					send_word(CMD_LOAD, rand_coord(), rand_coord(), 16'($urandom));
				rand_query();
				send_word(CMD_QUERY, pt_x[N_PTS-1], pt_y[N_PTS-1], 16'h0);
				send_word(CMD_LOAD, rand_coord(), rand_coord(), 16'($urandom));
				rand_query();
			end
			if (pt_count > 16 || $urandom_range(3) == 0)
				send_word(CMD_CLEAR, rand_coord(), rand_coord(), 16'($urandom));
			k = $urandom_range(1, 8);
			repeat (k)
				send_word(CMD_LOAD, rand_coord(), rand_coord(), 16'($urandom));
			k = $urandom_range(1, 5);
			repeat (k) begin
				if ($urandom_range(9) == 0)
					send_word(cmd_t'($urandom_range(3)), rand_coord(), rand_coord(),
						16'($urandom));
				else
					rand_query();
			end
		end
		req.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (!failed)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: shepard_idw_interpolator_core.f
+incdir+hdl
hdl/idw_pkg.sv
hdl/idw_ifs.sv
hdl/idw_div.sv
hdl/idw_sqrt.sv
hdl/idw_front.sv
hdl/idw_back.sv
hdl/shepard_idw_interpolator_core.sv
bench/tb_shepard_idw_interpolator_core.sv
